// File: rtl/core/bole_pkg.sv
package bole_pkg;

    localparam int DEPTH = 16;
    localparam int WIDTH = 32;

    localparam int KIND_W = 4;
    localparam int POS_W  = 5;
    localparam int DATA_W = 32;
    localparam int CNT_OUT_W = 5;
    localparam int STAT_W = 2;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    // common width for comparing a position against the occupancy
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [KIND_W-1:0] {
        CMD_APPEND       = 4'd0,
        CMD_PREPEND      = 4'd1,
        CMD_INSERT_AT    = 4'd2,
        CMD_REMOVE_FRONT = 4'd3,
        CMD_REMOVE_AT    = 4'd4,
        CMD_REMOVE_END   = 4'd5,
        CMD_READ         = 4'd6,
        CMD_WRITE        = 4'd7,
        CMD_CLEAR        = 4'd8
    } kind_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  position;
        logic [DATA_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic [DATA_W-1:0]    read_value;
        logic [CNT_OUT_W-1:0] count;
        status_t              status;
    } res_t;

endpackage

// File: rtl/core/bole_list.sv
module bole_list (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            commit,
    input  bole_pkg::cmd_t  cmd,
    output bole_pkg::res_t  res
);
    import bole_pkg::*;

    logic [WIDTH-1:0] ent_reg  [DEPTH];
    logic [WIDTH-1:0] ent_next [DEPTH];
    logic [CNT_W-1:0] occ_reg;
    logic [CNT_W-1:0] occ_next;

    logic [CMP_W-1:0] occ_ext;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] at;
    logic [IDX_W-1:0] at_idx;
    logic [WIDTH-1:0] wr_data;
    logic             do_ins;
    logic             do_rem;
    logic             do_wr;
    logic [DATA_W-1:0] rd;
    status_t          st;

    assign occ_ext = CMP_W'(occ_reg);
    assign pos_ext = CMP_W'(cmd.position);
    assign at_idx  = at[IDX_W-1:0];
    assign wr_data = WIDTH'(cmd.value);

    // command decode and checks: full before index, empty before index
    always_comb
    begin
        st       = ST_OK;
        rd       = '0;
        do_ins   = 1'b0;
        do_rem   = 1'b0;
        do_wr    = 1'b0;
        at       = '0;
        occ_next = occ_reg;
        case (kind_t'(cmd.kind))
            CMD_APPEND, CMD_PREPEND, CMD_INSERT_AT:
            begin
                if (occ_reg == CNT_W'(DEPTH))
                begin
                    st = ST_FULL;
                end
                else
                begin
                    if (kind_t'(cmd.kind) == CMD_APPEND)
                        at = occ_ext;
                    else if (kind_t'(cmd.kind) == CMD_PREPEND)
                        at = '0;
                    else
                        at = pos_ext;
                    if (at > occ_ext)
                    begin
                        st = ST_RANGE;
                    end
                    else
                    begin
                        do_ins   = 1'b1;
                        occ_next = occ_reg + CNT_W'(1);
                    end
                end
            end
            CMD_REMOVE_FRONT, CMD_REMOVE_AT, CMD_REMOVE_END, CMD_READ, CMD_WRITE:
            begin
                if (occ_reg == '0)
                begin
                    st = ST_EMPTY;
                end
                else
                begin
                    if (kind_t'(cmd.kind) == CMD_REMOVE_FRONT)
                        at = '0;
                    else if (kind_t'(cmd.kind) == CMD_REMOVE_END)
                        at = occ_ext - CMP_W'(1);
                    else
                        at = pos_ext;
                    if (at >= occ_ext)
                    begin
                        st = ST_RANGE;
                    end
                    else if (kind_t'(cmd.kind) == CMD_READ)
                    begin
                        rd = DATA_W'(ent_reg[at_idx]);
                    end
                    else if (kind_t'(cmd.kind) == CMD_WRITE)
                    begin
                        do_wr = 1'b1;
                    end
                    else
                    begin
                        rd       = DATA_W'(ent_reg[at_idx]);
                        do_rem   = 1'b1;
                        occ_next = occ_reg - CNT_W'(1);
                    end
                end
            end
            CMD_CLEAR:
            begin
                occ_next = '0;
            end
            default:
            begin
                occ_next = occ_reg;
            end
        endcase
    end

    // per-entry shift mux: every slot picks its neighbor, the new word or itself
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            ent_next[i] = ent_reg[i];
            if (do_ins)
            begin
                if (CMP_W'(i) == at)
                    ent_next[i] = wr_data;
                else if (i > 0 && CMP_W'(i) > at && CMP_W'(i) <= occ_ext)
                    ent_next[i] = ent_reg[(i > 0) ? i - 1 : 0];
            end
            else if (do_rem)
            begin
                if (i < DEPTH - 1 && CMP_W'(i) >= at && CMP_W'(i) + CMP_W'(1) < occ_ext)
                    ent_next[i] = ent_reg[(i < DEPTH - 1) ? i + 1 : i];
            end
            else if (do_wr)
            begin
                if (CMP_W'(i) == at)
                    ent_next[i] = wr_data;
            end
        end
    end

    assign res.read_value = rd;
    assign res.count      = CNT_OUT_W'(occ_next);
    assign res.status     = st;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            occ_reg <= '0;
        else if (commit)
            occ_reg <= occ_next;
    end

    // list words carry no reset
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            for (int i = 0; i < DEPTH; i++)
                ent_reg[i] <= ent_next[i];
        end
    end

endmodule

// File: rtl/core/bounded_ordered_list_engine_unit.sv
// Channel   Direction  Handshake            Beat fields
// -------   ---------  -------------------  -----------------------------
// in        input      in_valid / in_stall   kind, position, value
// out       output     out_valid / out_stall read_value, count, status
//
// Throughput: one command beat per cycle unless out_stall holds; the list
//   shifts in parallel between the command and result registers.
// Path: an accepted beat goes to the command register, then the result one.
// Reset: rst_n clears the occupancy and both valid flags, not the list words.
// Stalls: out_stall holds the result register; the command register then
//   fills and in_stall rises while it holds a pending beat.
module bounded_ordered_list_engine_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [bole_pkg::KIND_W-1:0]   kind,
    input  logic [bole_pkg::POS_W-1:0]    position,
    input  logic [bole_pkg::DATA_W-1:0]   value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [bole_pkg::DATA_W-1:0]   read_value,
    output logic [bole_pkg::CNT_OUT_W-1:0] count,
    output logic [bole_pkg::STAT_W-1:0]   status
);
    import bole_pkg::*;

    // command register
    logic cmd_valid_reg;
    logic cmd_valid_next;
    cmd_t cmd_reg;

    // result register
    logic res_valid_reg;
    logic res_valid_next;
    res_t res_reg;

    res_t res_comb;
    logic adv;      // result register can take a new beat
    logic commit;   // command register's beat applies to the list this cycle
    logic in_take;

    assign adv      = !res_valid_reg || !out_stall;
    assign commit   = cmd_valid_reg && adv;
    assign in_stall = cmd_valid_reg && !adv;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        cmd_valid_next = cmd_valid_reg;
        if (in_take)
            cmd_valid_next = 1'b1;
        else if (commit)
            cmd_valid_next = 1'b0;
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (adv)
            res_valid_next = cmd_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cmd_reg.kind     <= kind;
            cmd_reg.position <= position;
            cmd_reg.value    <= value;
        end
        if (commit)
            res_reg <= res_comb;
    end

    bole_list u_list (
        .clk    (clk),
        .rst_n  (rst_n),
        .commit (commit),
        .cmd    (cmd_reg),
        .res    (res_comb)
    );

    assign out_valid  = res_valid_reg;
    assign read_value = res_reg.read_value;
    assign count      = res_reg.count;
    assign status     = res_reg.status;

    // a full answer only ever comes with a full list
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_FULL |-> count == CNT_OUT_W'(DEPTH))
        else $error("full status with count below depth");

    // an empty answer comes with no entries and no data
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_EMPTY |-> count == '0 && read_value == '0)
        else $error("empty status with entries or data");

    // an accepted beat is held in the command register
    a_take_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> cmd_valid_reg)
        else $error("accepted beat lost");

    // a committed beat always produces a result beat
    a_commit_result: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> out_valid)
        else $error("committed beat without result");

endmodule

// File: tb/sv/ordered_list_checker.sv
module ordered_list_checker
    import bole_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic [KIND_W-1:0]    kind,
    input  logic [POS_W-1:0]     position,
    input  logic [DATA_W-1:0]    value,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic [DATA_W-1:0]    read_value,
    input  logic [CNT_OUT_W-1:0] count,
    input  logic [STAT_W-1:0]    status,
    output int                   mismatches,
    output int                   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // shadow copy of the list
    logic [WIDTH-1:0] list_words [DEPTH];
    int               list_len;
    res_t             awaited_results [$];
    int               err_tally;

    function automatic res_t apply_list_cmd(
        input logic [KIND_W-1:0] op,
        input logic [POS_W-1:0]  pos,
        input logic [DATA_W-1:0] word
    );
        res_t r;
        int   at;
        r.read_value = '0;
        r.status     = ST_OK;
        case (op)
            CMD_APPEND, CMD_PREPEND, CMD_INSERT_AT:
            begin
                if (list_len >= DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    at = (op == CMD_APPEND) ? list_len : (op == CMD_PREPEND) ? 0 : int'(pos);
                    if (at > list_len)
                    begin
                        r.status = ST_RANGE;
                    end
                    else
                    begin
                        for (int i = list_len; i > at; i--)
                            list_words[i] = list_words[i-1];
                        list_words[at] = word[WIDTH-1:0];
                        list_len++;
                    end
                end
            end
            CMD_REMOVE_FRONT, CMD_REMOVE_AT, CMD_REMOVE_END, CMD_READ, CMD_WRITE:
            begin
                if (list_len == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    at = (op == CMD_REMOVE_FRONT) ? 0 :
                         (op == CMD_REMOVE_END) ? list_len - 1 : int'(pos);
                    if (at >= list_len)
                    begin
                        r.status = ST_RANGE;
                    end
                    else if (op == CMD_READ)
                    begin
                        r.read_value = DATA_W'(list_words[at]);
                    end
                    else if (op == CMD_WRITE)
                    begin
                        list_words[at] = word[WIDTH-1:0];
                    end
                    else
                    begin
                        r.read_value = DATA_W'(list_words[at]);
                        for (int i = at; i + 1 < list_len; i++)
                            list_words[i] = list_words[i+1];
                        list_len--;
                    end
                end
            end
            CMD_CLEAR:
            begin
                list_len = 0;
            end
            default:
            begin
                // spare codes leave the list alone
            end
        endcase
        r.count = CNT_OUT_W'(list_len);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            list_len = 0;
            awaited_results.delete();
            err_tally = 0;
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                awaited_results.push_back(apply_list_cmd(kind, position, value));
            if (out_valid && !out_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: unexpected result beat read_value %h count %0d status %0d",
                             $time, read_value, count, status);
                    err_tally++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (read_value !== want.read_value)
                    begin
                        $display("%0t: read_value expected %h actual %h",
                                 $time, want.read_value, read_value);
                        err_tally++;
                    end
                    if (count !== want.count)
                    begin
                        $display("%0t: count expected %0d actual %0d",
                                 $time, want.count, count);
                        err_tally++;
                    end
                    if (status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, status);
                        err_tally++;
                    end
                end
            end
            mismatches  <= err_tally;
            outstanding <= awaited_results.size();
        end
    end

endmodule

// File: tb/sv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import bole_pkg::*;

    // Spare command codes: the block must answer them with no change.
    localparam logic [KIND_W-1:0] KIND_SPARE_LO = 4'd9;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI = 4'd15;

    // Worst case is far below this: ~475 beats, each at most a send gap plus
    // a result stall plus the pass through the command and result registers.
    localparam int CYCLE_LIMIT = 200000;

    // Flavor of a random stretch: grow the list, drain it, or anything.
    typedef enum { MIX_GROW, MIX_SHRINK, MIX_ANY } mix_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [KIND_W-1:0]    kind;
    logic [POS_W-1:0]     position;
    logic [DATA_W-1:0]    value;
    logic                 out_valid;
    logic                 out_stall;
    logic [DATA_W-1:0]    read_value;
    logic [CNT_OUT_W-1:0] count;
    logic [STAT_W-1:0]    status;

    int   mismatches;
    int   outstanding;
    int   cycle_count = 0;
    bit   idle_on;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    bounded_ordered_list_engine_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .position   (position),
        .value      (value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_value (read_value),
        .count      (count),
        .status     (status)
    );

    // Watches both channels, keeps its own copy of the list and scores
    // every result beat against the oldest pending expectation.
    ordered_list_checker watcher (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .position    (position),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_value  (read_value),
        .count       (count),
        .status      (status),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Hard stop: a hung handshake or a lost result ends here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Result side backpressure: random stall bursts while
    // idling is enabled, nothing otherwise.
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // One command beat. Called at a rising edge; an optional gap comes
    // first, then the beat is held until the edge where stall is low.
    task automatic send_cmd(
        input logic [KIND_W-1:0] k,
        input logic [POS_W-1:0]  p,
        input logic [DATA_W-1:0] v
    );
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        position <= p;
        value    <= v;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Stop sending and hold off until every result has come back. The
    // first edge lets the checker count a beat taken at the current edge.
    task automatic wait_drained;
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    function automatic logic [KIND_W-1:0] pick_kind(input mix_t mode);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            MIX_GROW:
            begin
                if (r < 30)      return CMD_APPEND;
                else if (r < 50) return CMD_PREPEND;
                else if (r < 75) return CMD_INSERT_AT;
                else if (r < 80) return CMD_REMOVE_FRONT;
                else if (r < 85) return CMD_REMOVE_AT;
                else if (r < 88) return CMD_REMOVE_END;
                else if (r < 94) return CMD_READ;
                else if (r < 98) return CMD_WRITE;
                else             return KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
            end
            MIX_SHRINK:
            begin
                if (r < 20)      return CMD_REMOVE_FRONT;
                else if (r < 45) return CMD_REMOVE_AT;
                else if (r < 65) return CMD_REMOVE_END;
                else if (r < 75) return CMD_READ;
                else if (r < 85) return CMD_WRITE;
                else if (r < 90) return CMD_APPEND;
                else if (r < 95) return CMD_INSERT_AT;
                else             return CMD_PREPEND;
            end
            default:
            begin
                if (r < 3)       return CMD_CLEAR;
                else if (r < 6)  return KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
                else             return KIND_W'($urandom_range(CMD_APPEND, CMD_WRITE));
            end
        endcase
    endfunction

    // Half the positions land low, where they are mostly in range even
    // for a short list; the rest run from 0 up to DEPTH (16).
    function automatic logic [POS_W-1:0] pick_position;
        if ($urandom_range(0, 1) == 0)
            return POS_W'($urandom_range(0, 4));
        return POS_W'($urandom_range(0, DEPTH));
    endfunction

    function automatic logic [DATA_W-1:0] pick_word;
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)      return '0;
        else if (r == 1) return '1;
        return $urandom;
    endfunction

    task automatic run_stretch(input mix_t mode, input int beats);
        for (int n = 0; n < beats; n++)
            send_cmd(pick_kind(mode), pick_position(), pick_word());
    endtask

    initial
    begin
        in_valid <= 1'b0;
        kind     <= CMD_APPEND;
        position <= '0;
        value    <= '0;
        rst_n    <= 1'b0;
        idle_on   = 1'b1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed ---
        // every access on an empty list reports empty
        send_cmd(CMD_REMOVE_FRONT, 5'd0, '0);
        send_cmd(CMD_REMOVE_AT,    5'd0, '0);
        send_cmd(CMD_REMOVE_END,   5'd0, '0);
        send_cmd(CMD_READ,         5'd0, '0);
        send_cmd(CMD_WRITE,        5'd0, 32'h0BAD_0BAD);
        // insert past the end is a bad index; at the end it appends
        send_cmd(CMD_INSERT_AT,    5'd1, 32'h1111_1111);
        send_cmd(CMD_INSERT_AT,    5'd0, 32'h0000_0000);
        send_cmd(CMD_APPEND,       5'd0, 32'hFFFF_FFFF);
        send_cmd(CMD_PREPEND,      5'd0, 32'h5555_5555);
        send_cmd(CMD_INSERT_AT,    5'd3, 32'hAAAA_AAAA);
        send_cmd(CMD_INSERT_AT,    5'd5, 32'h2222_2222);
        // read/write range edges, top position bit set
        send_cmd(CMD_READ,         5'd16, '0);
        send_cmd(CMD_READ,         5'd3,  '0);
        send_cmd(CMD_WRITE,        5'd2,  32'h1234_5678);
        send_cmd(CMD_READ,         5'd2,  '0);
        send_cmd(CMD_REMOVE_AT,    5'd4,  '0);
        send_cmd(CMD_REMOVE_AT,    5'd1,  '0);
        send_cmd(CMD_REMOVE_END,   5'd31, '0);
        // spare codes do nothing
        send_cmd(KIND_SPARE_LO,    5'd0,  32'hFFFF_FFFF);
        send_cmd(KIND_SPARE_HI,    5'd16, 32'hFFFF_FFFF);
        send_cmd(CMD_REMOVE_FRONT, 5'd0,  '0);
        send_cmd(CMD_CLEAR,        5'd0,  '0);
        send_cmd(CMD_READ,         5'd0,  '0);
        send_cmd(CMD_CLEAR,        5'd0,  '0);

        // --- random ---
        // grow stretches run into the full list, shrink ones empty it
        run_stretch(MIX_GROW,   60);
        run_stretch(MIX_SHRINK, 60);
        // sender holds off until the pipe is empty
        wait_drained();
        run_stretch(MIX_ANY,    80);
        idle_on = 1'b0;
        run_stretch(MIX_GROW,   50);
        idle_on = 1'b1;
        run_stretch(MIX_SHRINK, 70);
        wait_drained();
        run_stretch(MIX_ANY,    80);
        // tail at full rate, no gaps or stalls
        idle_on = 1'b0;
        run_stretch(MIX_GROW,   25);
        run_stretch(MIX_ANY,    25);

        wait_drained();
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: files.f
rtl/core/bole_pkg.sv
rtl/core/bole_list.sv
rtl/core/bounded_ordered_list_engine_unit.sv
tb/sv/ordered_list_checker.sv
tb/sv/testbench.sv
